@@ rtl/v4stc_pkg.sv @@
// Package: lane type codes and request/result payload structs for the vector converter.
`default_nettype none
package v4stc_pkg;

    typedef enum logic [1:0] {
        TY_BOOL  = 2'd0,
        TY_INT   = 2'd1,
        TY_FLOAT = 2'd2,
        TY_BAD   = 2'd3
    } t_lane_type;

    // lanes per vector; the payload structs below are laid out for this count
    localparam int LANE_COUNT = 4;

    localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;

    typedef struct packed {
        logic [1:0]  src_type;
        logic [1:0]  dst_type;
        logic [31:0] lane_0;
        logic [31:0] lane_1;
        logic [31:0] lane_2;
        logic [31:0] lane_3;
    } t_req;

    typedef struct packed {
        logic [31:0] out_lane_0;
        logic [31:0] out_lane_1;
        logic [31:0] out_lane_2;
        logic [31:0] out_lane_3;
        logic        type_error;
    } t_rsp;

endpackage
`default_nettype wire

@@ rtl/vec4_scalar_type_converter.sv @@
// Top level: four-lane bool/int32/float32 vector type converter.
// Usage:
//   Request channel: i_valid/o_stall with payload i_req (source type,
//   destination type, four raw 32-bit lanes). Result channel: o_valid/
//   i_stall with payload o_rsp (four converted lanes plus type_error).
//   A request is taken on a rising edge with valid high and stall low.
// Pipeline: an input register, then the per-lane conversion, then a result register.
// Throughput: one request per cycle; the converter logic is a single
//   pass with no loop, so the pipeline advances whenever the result
//   register is empty or being drained.
// Stall: when i_stall holds the result, the result stage holds; an empty
//   input stage still loads, and o_stall rises only if the input stage is
//   also full; a stalled result never changes.
// Reset: i_rst_n (synchronous, active low) empties both stages.
// Invalid type code (3) on either side gives zero lanes and type_error.
`default_nettype none
module vec4_scalar_type_converter
    import v4stc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);
    logic        r_in_vld;
    t_req        r_in;
    logic        r_out_vld;
    t_rsp        r_out;
    logic        out_adv;
    logic        in_adv;
    logic [31:0] cv [LANE_COUNT];
    logic [31:0] lanes [LANE_COUNT];
    logic        bad;

    assign out_adv = !r_out_vld || !i_stall;      // result register can load
    assign in_adv  = !r_in_vld || out_adv;        // input register can load
    assign o_stall = !in_adv;
    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

    assign lanes[0] = r_in.lane_0;
    assign lanes[1] = r_in.lane_1;
    assign lanes[2] = r_in.lane_2;
    assign lanes[3] = r_in.lane_3;
    assign bad = (r_in.src_type == TY_BAD) || (r_in.dst_type == TY_BAD);

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        v4stc_lane u_lane (
            .i_val(lanes[g]),
            .i_src(r_in.src_type),
            .i_dst(r_in.dst_type),
            .o_val(cv[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_adv) r_in_vld <= i_valid;
            if (out_adv) r_out_vld <= r_in_vld;
        end
        if (in_adv && i_valid) r_in <= i_req;
        if (out_adv && r_in_vld) begin
            r_out.out_lane_0 <= bad ? 32'd0 : cv[0];
            r_out.out_lane_1 <= bad ? 32'd0 : cv[1];
            r_out.out_lane_2 <= bad ? 32'd0 : cv[2];
            r_out.out_lane_3 <= bad ? 32'd0 : cv[3];
            r_out.type_error <= bad;
        end
    end

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");
    // stall to the sender only when both stages are full
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld && i_stall)
        else $error("spurious stall");
    // an error result carries zero lanes (checked on lanes 0 and 3)
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.type_error |-> o_rsp.out_lane_0 == 32'd0 && o_rsp.out_lane_3 == 32'd0)
        else $error("error result with nonzero lanes");
endmodule
`default_nettype wire

@@ rtl/v4stc_lane.sv @@
// Single-lane bool/int32/float32 converter (combinational).
`default_nettype none
module v4stc_lane
    import v4stc_pkg::*;
(
    input  wire logic [31:0] i_val,
    input  wire logic [1:0]  i_src,
    input  wire logic [1:0]  i_dst,
    output logic      [31:0] o_val
);
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic        rnd;
    logic [24:0] keep;
    logic [7:0]  ex;
    logic [31:0] i2f;
    logic [7:0]  fex;
    logic [31:0] fmag;
    logic [31:0] f2i;

    // int -> float: leading-one position, normalize, round nearest even
    always_comb begin
        mag  = i_val[31] ? (32'd0 - i_val) : i_val;
        p    = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (mag[k]) p = 5'(k);
        end
        norm = mag << (5'd31 - p);          // leading one at bit 31
        // guard is norm[7], sticky norm[6:0], lsb norm[8]
        rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
        keep = {1'b0, norm[31:8]} + {24'd0, rnd};
        ex   = 8'(p) + 8'd127;
        if (keep[24]) begin
            ex = ex + 8'd1;
        end
        if (mag == 32'd0) i2f = 32'd0;
        else i2f = {i_val[31], ex, keep[24] ? keep[23:1] : keep[22:0]};
    end

    // float -> int: truncate, saturate, NaN to zero
    always_comb begin
        fex  = i_val[30:23];
        fmag = {8'd0, 1'b1, i_val[22:0]};
        if (fex >= 8'd150) fmag = fmag << 5'(fex - 8'd150);
        else fmag = fmag >> 5'(8'd150 - fex);
        if (fex == 8'hFF && i_val[22:0] != 23'd0) f2i = 32'd0;
        else if (fex < 8'd127) f2i = 32'd0;
        else if (fex >= 8'd158) f2i = i_val[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else f2i = i_val[31] ? (32'd0 - fmag) : fmag;
    end

    always_comb begin
        if (i_src == i_dst) o_val = i_val;
        else begin
            case (i_src)
                TY_BOOL: o_val = (i_val == 32'd0) ? 32'd0 :
                                 ((i_dst == TY_INT) ? 32'd1 : FLOAT_ONE);
                TY_INT:  o_val = (i_dst == TY_BOOL) ? {31'd0, i_val != 32'd0} : i2f;
                default: o_val = (i_dst == TY_BOOL) ? {31'd0, i_val[30:0] != 31'd0} : f2i;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ verif/tb_vec4_scalar_type_converter.sv @@
// Testbench for the four-lane bool/int32/float32 vector type converter.
`default_nettype none
module tb_vec4_scalar_type_converter;
    import v4stc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    vec4_scalar_type_converter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    always #10 i_clk = ~i_clk;

    t_req   pending_reqs[$];
    t_rsp   expected_rsps[$];
    bit     failed = 1'b0;
    bit     calm = 1'b0;        // no random idling on either side
    bit     hold_rx = 1'b0;     // receiver holds off for a long stretch
    int     hold_cnt = 0;
    int     idle_cycles = 0;

    // Signed int32 to single float, round to nearest even.
    function automatic logic [31:0] int_to_single(logic [31:0] v);
        logic [31:0] mag, keep, rem, half;
        int          p, sh;
        mag = v[31] ? -v : v;
        if (mag == 0) return 32'h0;
        p = 31;
        while (!mag[p]) p--;
        if (p <= 23) begin
            keep = mag << (23 - p);
        end else begin
            sh = p - 23;
            rem = mag & ((32'h1 << sh) - 1);
            half = 32'h1 << (sh - 1);
            keep = mag >> sh;
            if (rem > half || (rem == half && keep[0])) keep++;
            if (keep == 32'h0100_0000) begin
                keep = keep >> 1;
                p++;
            end
        end
        return {v[31], 8'(p + 127), keep[22:0]};
    endfunction

    // Single float to int32: truncate, saturate, NaN gives zero.
    function automatic logic [31:0] single_to_int(logic [31:0] v);
        logic [7:0]  ex;
        logic [31:0] mag;
        int          e;
        ex = v[30:23];
        if (ex == 8'hFF && v[22:0] != 0) return 32'h0;
        if (ex < 127) return 32'h0;
        e = ex - 127;
        if (e >= 31) return v[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mag = {9'h1, v[22:0]};
        if (e >= 23) mag = mag << (e - 23);
        else mag = mag >> (23 - e);
        return v[31] ? -mag : mag;
    endfunction

    function automatic logic [31:0] convert_lane(logic [31:0] v, t_lane_type src,
                                                 t_lane_type dst);
        if (src == dst) return v;
        case (src)
            TY_BOOL: begin
                if (dst == TY_INT) return {31'h0, v != 0};
                return (v != 0) ? FLOAT_ONE : 32'h0;
            end
            TY_INT: begin
                if (dst == TY_BOOL) return {31'h0, v != 0};
                return int_to_single(v);
            end
            default: begin
                if (dst == TY_BOOL) return {31'h0, v[30:0] != 0};
                return single_to_int(v);
            end
        endcase
    endfunction

    function automatic t_rsp convert_vector(t_req r);
        t_rsp       res;
        t_lane_type src, dst;
        src = t_lane_type'(r.src_type);
        dst = t_lane_type'(r.dst_type);
        res = '0;
        if (src == TY_BAD || dst == TY_BAD) begin
            res.type_error = 1'b1;
        end else begin
            res.out_lane_0 = convert_lane(r.lane_0, src, dst);
            res.out_lane_1 = convert_lane(r.lane_1, src, dst);
            res.out_lane_2 = convert_lane(r.lane_2, src, dst);
            res.out_lane_3 = convert_lane(r.lane_3, src, dst);
        end
        return res;
    endfunction

    // Lane value biased toward interesting patterns for the given type.
    function automatic logic [31:0] pick_lane(logic [1:0] ty);
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'hFFFF_FFFF;
            4: return {31'h0, 1'($urandom)};
            5: return {1'($urandom), 8'($urandom_range(120, 160)), 23'($urandom)};
            6: return {1'($urandom), 8'hFF, ($urandom_range(0, 1) ? 23'h0 : 23'($urandom))};
            7: return $urandom >> $urandom_range(0, 31);
            default: return (ty == TY_BOOL && $urandom_range(0, 1)) ?
                            {31'h0, 1'($urandom)} : $urandom;
        endcase
    endfunction

    function automatic t_req make_req(logic [1:0] src, logic [1:0] dst);
        t_req r;
        r.src_type = src;
        r.dst_type = dst;
        r.lane_0 = pick_lane(src);
        r.lane_1 = pick_lane(src);
        r.lane_2 = pick_lane(src);
        r.lane_3 = pick_lane(src);
        return r;
    endfunction

    // Driver: offers the next pending request; keeps it steady while stalled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 28)) begin
                    i_req <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Predict when a request is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            expected_rsps.push_back(convert_vector(i_req));
    end

    // Monitor: check each result against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t unexpected result: actual %h", $time, o_rsp);
                failed = 1'b1;
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.out_lane_0 !== want.out_lane_0) begin
                    $display("%0t out_lane_0: expected %h actual %h", $time,
                             want.out_lane_0, o_rsp.out_lane_0);
                    failed = 1'b1;
                end
                if (o_rsp.out_lane_1 !== want.out_lane_1) begin
                    $display("%0t out_lane_1: expected %h actual %h", $time,
                             want.out_lane_1, o_rsp.out_lane_1);
                    failed = 1'b1;
                end
                if (o_rsp.out_lane_2 !== want.out_lane_2) begin
                    $display("%0t out_lane_2: expected %h actual %h", $time,
                             want.out_lane_2, o_rsp.out_lane_2);
                    failed = 1'b1;
                end
                if (o_rsp.out_lane_3 !== want.out_lane_3) begin
                    $display("%0t out_lane_3: expected %h actual %h", $time,
                             want.out_lane_3, o_rsp.out_lane_3);
                    failed = 1'b1;
                end
                if (o_rsp.type_error !== want.type_error) begin
                    $display("%0t type_error: expected %b actual %b", $time,
                             want.type_error, o_rsp.type_error);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver stall: random, or a long counted hold-off.
    always @(posedge i_clk) begin
        if (hold_rx && hold_cnt < 60) begin
            hold_cnt <= hold_cnt + 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(0, 99) < 28);
        end
    end

    // Watchdog on cycles with no accepted transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_req r;
        int   k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every type pair, with edge patterns in every lane.
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < 4; d++) begin
                r.src_type = 2'(s);
                r.dst_type = 2'(d);
                r.lane_0 = 32'h0;
                r.lane_1 = 32'h8000_0000;
                r.lane_2 = 32'hFFFF_FFFF;
                r.lane_3 = (s == TY_BOOL) ? 32'h1 : 32'h7FFF_FFFF;
                pending_reqs.push_back(r);
            end
        end
        // Specials: float infinities, NaN, one, large, ties for int-to-float rounding, bool values.
        pending_reqs.push_back(t_req'{TY_FLOAT, TY_INT, 32'h7F80_0000, 32'hFF80_0000,
                                      32'h7FC0_0000, 32'hBFC0_0000});
        pending_reqs.push_back(t_req'{TY_FLOAT, TY_INT, 32'h4EFF_FFFF, 32'h4F00_0000,
                                      32'hCF00_0000, 32'h3F7F_FFFF});
        pending_reqs.push_back(t_req'{TY_FLOAT, TY_BOOL, 32'h8000_0000, 32'h7FC0_0000,
                                      32'h0000_0001, 32'h3F80_0000});
        pending_reqs.push_back(t_req'{TY_INT, TY_FLOAT, 32'h0100_0001, 32'h0100_0003,
                                      32'h00FF_FFFF, 32'hFEFF_FFFF});
        pending_reqs.push_back(t_req'{TY_BOOL, TY_FLOAT, 32'h2, 32'h1, 32'h0,
                                      32'h8000_0000});
        pending_reqs.push_back(t_req'{TY_BOOL, TY_BOOL, 32'h5, 32'hFFFF_FFFF, 32'h0,
                                      32'h1});

        // Random, with a calm stretch and a receiver hold-off along the way.
        for (k = 0; k < 450; k++) begin
            if (k == 100) begin
                wait (pending_reqs.size() == 0);
                calm = 1'b1;
            end
            if (k == 200) begin
                wait (pending_reqs.size() == 0);
                calm = 1'b0;
                hold_rx = 1'b1;
            end
            if (k == 300) begin
                // Sender pauses until every result is in.
                wait (pending_reqs.size() == 0 && !i_valid && expected_rsps.size() == 0);
            end
            pending_reqs.push_back(make_req(
                $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2))));
        end

        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        wait (!i_valid && expected_rsps.size() == 0);
        repeat (10) @(posedge i_clk);
        if (!failed && expected_rsps.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ vec4_scalar_type_converter.f @@
rtl/v4stc_pkg.sv
rtl/v4stc_lane.sv
rtl/vec4_scalar_type_converter.sv
verif/tb_vec4_scalar_type_converter.sv
